// ===== rtl/sacl_pkg.sv =====
// Shared types and constants for the set-associative cache block.
// No dependencies; imported by every module under rtl.
package sacl_pkg;
    localparam int MAX_SETS_DEF  = 256;
    localparam int MAX_WAYS_DEF  = 8;
    localparam int ADDR_BITS_DEF = 48;
    localparam int CNT_W         = 32;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 4;

    typedef enum logic [1:0] {
        REG_SET_INDEX_BITS    = 2'd0,
        REG_BLOCK_OFFSET_BITS = 2'd1,
        REG_WAYS_IN_USE       = 2'd2,
        REG_POLICY            = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        POLICY_LRU  = 1'b0,
        POLICY_FIFO = 1'b1
    } policy_t;

    typedef enum logic [1:0] {
        BK_IDLE  = 2'd0,
        BK_READ  = 2'd1,
        BK_EVAL  = 2'd2,
        BK_CLEAR = 2'd3
    } bk_state_t;
endpackage

// ===== rtl/sacl_front.sv =====
// Front end: accepts access beats, splits the address into set and tag, and
// queues the classified request for the back end. Depends on sacl_pkg.
module sacl_front
    import sacl_pkg::*;
#(
    parameter int MAX_SETS  = MAX_SETS_DEF,
    parameter int ADDR_BITS = ADDR_BITS_DEF,
    parameter int SET_W     = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [ADDR_BITS-1:0] in_addr,
    input  logic                 in_write,
    input  logic [3:0]           set_index_bits,
    input  logic [3:0]           block_offset_bits,
    output logic                 q_valid,
    input  logic                 q_ready,
    output logic [SET_W-1:0]     q_set,
    output logic [ADDR_BITS-1:0] q_tag,
    output logic                 q_write
);
    localparam int MAX_SIB = $clog2(MAX_SETS);

    logic [3:0]           sib;
    logic [ADDR_BITS-1:0] shifted;
    logic [ADDR_BITS-1:0] set_mask;
    logic [ADDR_BITS-1:0] set_full;
    logic [ADDR_BITS-1:0] tag_val;

    // Two-entry queue.
    logic [SET_W-1:0]     set_reg [2];
    logic [ADDR_BITS-1:0] tag_reg [2];
    logic                 wr_reg  [2];
    logic                 wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0]           cnt_reg, cnt_next;
    logic                 push, pop;

    always_comb begin
        sib = (set_index_bits > 4'(MAX_SIB)) ? 4'(MAX_SIB) : set_index_bits;
        shifted  = in_addr >> block_offset_bits;
        set_mask = ~({ADDR_BITS{1'b1}} << sib);
        set_full = shifted & set_mask;
        tag_val  = shifted >> sib;
    end

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_set    = set_reg[rp_reg];
    assign q_tag    = tag_reg[rp_reg];
    assign q_write  = wr_reg[rp_reg];

    always_comb begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            set_reg[wp_reg] <= set_full[SET_W-1:0];
            tag_reg[wp_reg] <= tag_val;
            wr_reg[wp_reg]  <= in_write;
        end
    end

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3) else $error("queue count out of range");
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd2) |-> !in_ready) else $error("accept while queue full");
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd0) |-> !q_valid) else $error("queue valid when empty");
endmodule

// ===== rtl/sacl_back.sv =====
// Back end: reads one set of the tag, valid and age stores, decides hit or
// victim, writes the set back and keeps the totals. Depends on sacl_pkg.
module sacl_back
    import sacl_pkg::*;
#(
    parameter int MAX_SETS  = MAX_SETS_DEF,
    parameter int MAX_WAYS  = MAX_WAYS_DEF,
    parameter int ADDR_BITS = ADDR_BITS_DEF,
    parameter int SET_W     = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  logic [SET_W-1:0]     q_set,
    input  logic [ADDR_BITS-1:0] q_tag,
    input  logic                 q_write,
    input  logic [3:0]           ways_in_use,
    input  logic                 policy,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 out_hit,
    output logic                 out_mem_read,
    output logic                 out_mem_write,
    output logic [CNT_W-1:0]     out_read_total,
    output logic [CNT_W-1:0]     out_write_total,
    output logic [CNT_W-1:0]     out_hit_total,
    output logic [CNT_W-1:0]     out_miss_total
);
    localparam int AGE_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(MAX_WAYS - 1);

    typedef logic [AGE_W-1:0] age_t;

    // Set-wide memories: one row holds every way of a set.
    logic [MAX_WAYS*ADDR_BITS-1:0] tag_mem [MAX_SETS];
    logic [MAX_WAYS*AGE_W-1:0]     age_mem [MAX_SETS];
    logic [MAX_WAYS-1:0]           vld_mem [MAX_SETS];

    logic [MAX_WAYS*ADDR_BITS-1:0] tag_rd_reg;
    logic [MAX_WAYS*AGE_W-1:0]     age_rd_reg;
    logic [MAX_WAYS-1:0]           vld_rd_reg;

    bk_state_t            st_reg, st_next;
    logic [SET_W-1:0]     clr_reg;
    logic [SET_W-1:0]     set_reg;
    logic [ADDR_BITS-1:0] tag_reg;
    logic                 wr_reg;

    logic                 ovalid_reg, ovalid_next;
    logic                 ohit_reg, owr_reg;
    logic [CNT_W-1:0]     rd_cnt_reg, wr_cnt_reg, hit_cnt_reg, miss_cnt_reg;

    logic [4:0]           ways;
    logic [MAX_WAYS-1:0]  in_use, match, freev;
    logic                 hit, found_free;
    logic [WAY_W-1:0]     hway, fway, oway, victim;
    age_t                 best, hage;
    age_t                 age [MAX_WAYS];
    logic [MAX_WAYS*AGE_W-1:0]     age_wb;
    logic [MAX_WAYS*ADDR_BITS-1:0] tag_wb;
    logic [MAX_WAYS-1:0]           vld_wb;
    logic                 do_eval;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        sat_inc = (c == '1) ? c : c + 1'b1;
    endfunction

    always_comb begin
        if (ways_in_use == 4'd0) ways = 5'd1;
        else if (5'(ways_in_use) > 5'(MAX_WAYS)) ways = 5'(MAX_WAYS);
        else ways = 5'(ways_in_use);
    end

    // Hit, free-way and oldest-way search over one set, and the row to write back.
    always_comb begin
        hit = 1'b0; hway = '0; found_free = 1'b0; fway = '0;
        best = '0; oway = '0; hage = '0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            in_use[w] = (5'(w) < ways);
            age[w]    = age_rd_reg[w*AGE_W +: AGE_W];
            match[w]  = in_use[w] && vld_rd_reg[w] &&
                        (tag_rd_reg[w*ADDR_BITS +: ADDR_BITS] == tag_reg);
            freev[w]  = in_use[w] && !vld_rd_reg[w];
        end
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (match[w]) begin hit = 1'b1; hway = WAY_W'(w); end
            if (freev[w]) begin found_free = 1'b1; fway = WAY_W'(w); end
        end
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (in_use[w] && (w == 0 || age[w] > best)) begin
                best = age[w]; oway = WAY_W'(w);
            end
        end
        hage   = age[hway];
        victim = found_free ? fway : oway;
        tag_wb = tag_rd_reg;
        vld_wb = vld_rd_reg;
        age_wb = age_rd_reg;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (hit) begin
                if (policy == POLICY_LRU) begin
                    if (WAY_W'(w) == hway)
                        age_wb[w*AGE_W +: AGE_W] = '0;
                    else if (in_use[w] && vld_rd_reg[w] && age[w] < hage)
                        age_wb[w*AGE_W +: AGE_W] = (age[w] < AGE_MAX) ? age[w] + 1'b1 : age[w];
                end
            end else begin
                if (WAY_W'(w) == victim) begin
                    age_wb[w*AGE_W +: AGE_W]     = '0;
                    tag_wb[w*ADDR_BITS +: ADDR_BITS] = tag_reg;
                    vld_wb[w] = 1'b1;
                end else if (in_use[w] && vld_rd_reg[w]) begin
                    age_wb[w*AGE_W +: AGE_W] = (age[w] < AGE_MAX) ? age[w] + 1'b1 : age[w];
                end
            end
        end
    end

    always_comb begin
        st_next     = st_reg;
        q_ready     = 1'b0;
        do_eval     = 1'b0;
        ovalid_next = ovalid_reg && !out_ready;
        case (st_reg)
            BK_CLEAR: begin
                if (clr_reg == SET_W'(MAX_SETS - 1)) st_next = BK_IDLE;
            end
            BK_IDLE: begin
                q_ready = 1'b1;
                if (q_valid) st_next = BK_READ;
            end
            BK_READ: st_next = BK_EVAL;
            BK_EVAL: begin
                if (!ovalid_reg || out_ready) begin
                    do_eval     = 1'b1;
                    ovalid_next = 1'b1;
                    st_next     = BK_IDLE;
                end
            end
            default: st_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg       <= BK_CLEAR;
            clr_reg      <= '0;
            ovalid_reg   <= 1'b0;
            rd_cnt_reg   <= '0;
            wr_cnt_reg   <= '0;
            hit_cnt_reg  <= '0;
            miss_cnt_reg <= '0;
        end else begin
            st_reg     <= st_next;
            ovalid_reg <= ovalid_next;
            if (st_reg == BK_CLEAR) clr_reg <= clr_reg + 1'b1;
            if (do_eval) begin
                if (hit) hit_cnt_reg <= sat_inc(hit_cnt_reg);
                else begin
                    miss_cnt_reg <= sat_inc(miss_cnt_reg);
                    rd_cnt_reg   <= sat_inc(rd_cnt_reg);
                end
                if (wr_reg) wr_cnt_reg <= sat_inc(wr_cnt_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_valid && q_ready) begin
            set_reg <= q_set;
            tag_reg <= q_tag;
            wr_reg  <= q_write;
        end
        if (st_reg == BK_READ) begin
            tag_rd_reg <= tag_mem[set_reg];
            age_rd_reg <= age_mem[set_reg];
        end
        if (do_eval) begin
            tag_mem[set_reg] <= tag_wb;
            age_mem[set_reg] <= age_wb;
            ohit_reg <= hit;
            owr_reg  <= wr_reg;
        end
    end

    // Valid rows live in a memory of their own; after reset one row a cycle is cleared.
    always_ff @(posedge aclk) begin
        if (st_reg == BK_CLEAR) vld_mem[clr_reg] <= '0;
        else if (do_eval) vld_mem[set_reg] <= vld_wb;
        if (st_reg == BK_READ) vld_rd_reg <= vld_mem[set_reg];
    end

    assign out_valid       = ovalid_reg;
    assign out_hit         = ohit_reg;
    assign out_mem_read    = !ohit_reg;
    assign out_mem_write   = owr_reg;
    assign out_read_total  = rd_cnt_reg;
    assign out_write_total = wr_cnt_reg;
    assign out_hit_total   = hit_cnt_reg;
    assign out_miss_total  = miss_cnt_reg;

    a_one_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == BK_EVAL) |-> (match == '0 || hit)) else $error("match lost");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (ovalid_reg && !out_ready) |=> ovalid_reg) else $error("result dropped");
    a_eval_after_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == BK_READ) |=> (st_reg == BK_EVAL)) else $error("read not followed");
endmodule

// ===== rtl/set_assoc_cache_lru_fifo.sv =====
// Top level of the set-associative cache model with LRU or FIFO replacement.
// Depends on sacl_pkg, sacl_front and sacl_back.
//
//  Group    Dir  tdata / data fields (low bit up)
//  s_axis   in   access_address[47:0], is_write[48]   (56-bit tdata)
//  m_axis   out  hit, memory_read, memory_write, read_total, write_total,
//                hit_total, miss_total                (136-bit tdata)
//  cfg      in   cfg_index (register number), cfg_data
//
// In the back end an access goes through taking the request from the queue,
// the registered read of the set row, and evaluating and writing the row back.
// The front end splits the address in the accept cycle and holds up to two
// requests. Reset is synchronous and clears control state; the back end then
// clears the valid rows one set per cycle and takes no request until that pass
// is done. A stalled result beat holds its register; the back end waits before
// evaluating the next access until that beat is taken.
module set_assoc_cache_lru_fifo
    import sacl_pkg::*;
#(
    parameter int MAX_SETS  = MAX_SETS_DEF,
    parameter int MAX_WAYS  = MAX_WAYS_DEF,
    parameter int ADDR_BITS = ADDR_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // access_address, is_write
    input  logic [((ADDR_BITS+1+7)/8)*8-1:0] s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // hit, memory_read, memory_write, read_total, write_total, hit_total, miss_total
    output logic [135:0]          m_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);
    localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;

    logic [3:0] sib_reg, bob_reg, ways_reg;
    logic       pol_reg;

    logic                 q_valid, q_ready, q_write;
    logic [SET_W-1:0]     q_set;
    logic [ADDR_BITS-1:0] q_tag;
    logic                 o_hit, o_rd, o_wr;
    logic [CNT_W-1:0]     rt, wt, ht, mt;

    assign cfg_ready = 1'b1;

    // Config regs. Writes must arrive only while the block is idle; not enforced.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sib_reg  <= 4'd0;
            bob_reg  <= 4'd6;
            ways_reg <= 4'd1;
            pol_reg  <= POLICY_LRU;
        end else if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_SET_INDEX_BITS:    sib_reg  <= cfg_data;
                REG_BLOCK_OFFSET_BITS: bob_reg  <= cfg_data;
                REG_WAYS_IN_USE:       ways_reg <= cfg_data;
                REG_POLICY:            pol_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    sacl_front #(.MAX_SETS(MAX_SETS), .ADDR_BITS(ADDR_BITS), .SET_W(SET_W)) u_front (
        .aclk, .aresetn,
        .in_valid(s_tvalid), .in_ready(s_tready),
        .in_addr(s_tdata[ADDR_BITS-1:0]), .in_write(s_tdata[ADDR_BITS]),
        .set_index_bits(sib_reg), .block_offset_bits(bob_reg),
        .q_valid, .q_ready, .q_set, .q_tag, .q_write
    );

    sacl_back #(.MAX_SETS(MAX_SETS), .MAX_WAYS(MAX_WAYS), .ADDR_BITS(ADDR_BITS),
                .SET_W(SET_W)) u_back (
        .aclk, .aresetn,
        .q_valid, .q_ready, .q_set, .q_tag, .q_write,
        .ways_in_use(ways_reg), .policy(pol_reg),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .out_hit(o_hit), .out_mem_read(o_rd), .out_mem_write(o_wr),
        .out_read_total(rt), .out_write_total(wt),
        .out_hit_total(ht), .out_miss_total(mt)
    );

    assign m_tdata = {5'd0, mt, ht, wt, rt, o_wr, o_rd, o_hit};
endmodule

// ===== tb/set_assoc_cache_lru_fifo_chk.sv =====
// Checker for the set-associative cache: watches the access, result and register
// channels, predicts every result beat and compares it field by field.
// Depends on sacl_pkg.
module set_assoc_cache_lru_fifo_chk
    import sacl_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    input  logic          s_tready,
    input  logic [55:0]   s_tdata,
    input  logic          m_tvalid,
    input  logic          m_tready,
    input  logic [135:0]  m_tdata,
    input  logic          cfg_valid,
    input  logic          cfg_ready,
    input  logic [1:0]    cfg_index,
    input  logic [3:0]    cfg_data,
    output int            fail_count,
    output int            pending_count,
    output int            hit_seen,
    output int            result_seen
);
    localparam int SETS = 256;
    localparam int WAYS = 8;

    typedef struct packed {
        logic        hit;
        logic        memory_read;
        logic        memory_write;
        logic [31:0] read_total;
        logic [31:0] write_total;
        logic [31:0] hit_total;
        logic [31:0] miss_total;
    } access_result_t;

    logic [3:0]  sib_reg, bob_reg, ways_reg;
    policy_t     policy_reg;
    logic [47:0] tag_mem [SETS*WAYS];
    logic        valid_mem [SETS*WAYS];
    logic [2:0]  age_mem [SETS*WAYS];
    logic [31:0] rd_cnt, wr_cnt, hit_cnt, miss_cnt;
    access_result_t expected_results [$];

    function automatic logic [31:0] sat_add(input logic [31:0] c);
        return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
    endfunction

    function automatic logic [2:0] age_add(input logic [2:0] a);
        return (a < 3'(WAYS - 1)) ? a + 3'd1 : a;
    endfunction

    // Cache lookup and update for one access; returns the predicted result beat.
    function automatic access_result_t cache_access(input logic [47:0] addr,
                                                    input logic wr);
        access_result_t r;
        int sib, ways, set_no, base, hway, victim, best;
        logic [47:0] tag;
        logic hit, free_found;
        logic [2:0] old;
        sib = int'(sib_reg);
        ways = int'(ways_reg);
        hit = 1'b0;
        hway = 0;
        free_found = 1'b0;
        victim = 0;
        best = -1;
        if (sib > 8) sib = 8;
        if (ways == 0) ways = 1;
        if (ways > WAYS) ways = WAYS;
        set_no = int'((addr >> bob_reg) & ((48'd1 << sib) - 48'd1));
        tag = addr >> (bob_reg + sib);
        base = set_no * WAYS;
        for (int w = 0; w < ways; w++)
            if (!hit && valid_mem[base+w] && tag_mem[base+w] == tag) begin
                hit = 1'b1;
                hway = w;
            end
        if (hit) begin
            hit_cnt = sat_add(hit_cnt);
            if (policy_reg == POLICY_LRU) begin
                old = age_mem[base+hway];
                for (int w = 0; w < ways; w++)
                    if (w != hway && valid_mem[base+w] && age_mem[base+w] < old)
                        age_mem[base+w] = age_add(age_mem[base+w]);
                age_mem[base+hway] = 3'd0;
            end
        end else begin
            miss_cnt = sat_add(miss_cnt);
            rd_cnt = sat_add(rd_cnt);
            for (int w = 0; w < ways; w++)
                if (!free_found && !valid_mem[base+w]) begin
                    free_found = 1'b1;
                    victim = w;
                end
            if (!free_found)
                for (int w = 0; w < ways; w++)
                    if (int'(age_mem[base+w]) > best) begin
                        best = int'(age_mem[base+w]);
                        victim = w;
                    end
            for (int w = 0; w < ways; w++)
                if (w != victim && valid_mem[base+w])
                    age_mem[base+w] = age_add(age_mem[base+w]);
            tag_mem[base+victim] = tag;
            valid_mem[base+victim] = 1'b1;
            age_mem[base+victim] = 3'd0;
        end
        if (wr) wr_cnt = sat_add(wr_cnt);
        r.hit = hit;
        r.memory_read = !hit;
        r.memory_write = wr;
        r.read_total = rd_cnt;
        r.write_total = wr_cnt;
        r.hit_total = hit_cnt;
        r.miss_total = miss_cnt;
        return r;
    endfunction

    always @(posedge aclk) begin
        access_result_t got, want;
        if (!aresetn) begin
            sib_reg <= 4'd0;
            bob_reg <= 4'd6;
            ways_reg <= 4'd1;
            policy_reg <= POLICY_LRU;
            for (int i = 0; i < SETS*WAYS; i++) begin
                valid_mem[i] = 1'b0;
                age_mem[i] = 3'd0;
            end
            rd_cnt = '0;
            wr_cnt = '0;
            hit_cnt = '0;
            miss_cnt = '0;
            expected_results.delete();
            fail_count <= 0;
            hit_seen <= 0;
            result_seen <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_reg_t'(cfg_index))
                    REG_SET_INDEX_BITS:    sib_reg <= cfg_data;
                    REG_BLOCK_OFFSET_BITS: bob_reg <= cfg_data;
                    REG_WAYS_IN_USE:       ways_reg <= cfg_data;
                    REG_POLICY:            policy_reg <= policy_t'(cfg_data[0]);
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(cache_access(s_tdata[47:0], s_tdata[48]));
            if (m_tvalid && m_tready) begin
                got = access_result_t'({m_tdata[0], m_tdata[1], m_tdata[2], m_tdata[34:3],
                                        m_tdata[66:35], m_tdata[98:67], m_tdata[130:99]});
                result_seen <= result_seen + 1;
                if (got.hit) hit_seen <= hit_seen + 1;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result beat, actual %h", $time, got);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (got != want) begin
                        $display("%0t: mismatch expected hit=%0b rd=%0b wr=%0b tot=%0d/%0d/%0d/%0d",
                                 $time, want.hit, want.memory_read, want.memory_write,
                                 want.read_total, want.write_total, want.hit_total,
                                 want.miss_total);
                        $display("%0t:          actual   hit=%0b rd=%0b wr=%0b tot=%0d/%0d/%0d/%0d",
                                 $time, got.hit, got.memory_read, got.memory_write,
                                 got.read_total, got.write_total, got.hit_total,
                                 got.miss_total);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

    assign pending_count = expected_results.size();
endmodule

// ===== tb/set_assoc_cache_lru_fifo_tb.sv =====
// Testbench top for the set-associative cache: drives accesses and register
// writes and gives the verdict. Depends on sacl_pkg and the checker module.
module set_assoc_cache_lru_fifo_tb
    import sacl_pkg::*;
();

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    // access_address[47:0], is_write[48], zero fill up to bit 55
    logic [55:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    // hit, memory_read, memory_write, read_total, write_total, hit_total, miss_total
    logic [135:0] m_tdata;
    logic         cfg_valid = 0;
    logic         cfg_ready;
    logic [1:0]   cfg_index = '0;
    logic [3:0]   cfg_data = '0;
    int           fail_count, pending_count, hit_seen, result_seen;

    // Idle odds in percent for the sender and the receiver.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int access_count = 0;

    always begin
        #2 aclk = 1;
        #2 aclk = 0;
    end

    set_assoc_cache_lru_fifo u_top (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready,
        .m_tdata, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
    );

    set_assoc_cache_lru_fifo_chk u_chk (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready,
        .m_tdata, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
        .fail_count, .pending_count, .hit_seen, .result_seen
    );

    // The receiver stalls at random on each falling edge at the current odds.
    always @(negedge aclk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    // Sends one access beat, idling first at the sender's odds. Ready only moves
    // at rising edges, so its value at a falling edge holds for the next rising one.
    task automatic send_access(input logic [47:0] addr, input logic wr);
        while ($urandom_range(99) < send_idle_pct) @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata = {7'd0, wr, addr};
        while (!s_tready) @(negedge aclk);
        @(negedge aclk);
        s_tvalid = 1'b0;
        access_count++;
    endtask

    // Lets the pipeline drain, then writes one register while the block is idle.
    task automatic write_reg(input cfg_reg_t idx, input logic [3:0] val);
        while (pending_count != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 0;
    endtask

    task automatic set_geometry(input logic [3:0] sib, input logic [3:0] bob,
                                input logic [3:0] ways, input policy_t pol);
        write_reg(REG_SET_INDEX_BITS, sib);
        write_reg(REG_BLOCK_OFFSET_BITS, bob);
        write_reg(REG_WAYS_IN_USE, ways);
        write_reg(REG_POLICY, 4'(pol));
    endtask

    // Random accesses mostly drawn from a small pool of blocks so that sets fill,
    // lines hit and evictions happen; a few fully random addresses add noise.
    task automatic random_phase(input int count);
        logic [47:0] pool [16];
        logic [47:0] addr;
        for (int i = 0; i < 16; i++)
            pool[i] = 48'({$urandom(), $urandom()}) & 48'h0000_0003_FFFF;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(9) == 0)
                addr = 48'({$urandom(), $urandom()});
            else
                addr = pool[$urandom_range(15)] ^ 48'($urandom_range(3));
            send_access(addr, 1'($urandom_range(1)));
        end
    endtask

    initial begin
        policy_t pol;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;

        // Directed: reset geometry, address extremes, hits and misses of both kinds.
        send_access(48'h0, 0);
        send_access(48'h0, 1);
        send_access(48'hFFFF_FFFF_FFFF, 1);
        send_access(48'hFFFF_FFFF_FFC0, 0);
        send_access(48'h0000_0000_0040, 0);
        // Too many sets and too many ways clamp; a later zero-ways setting acts as one.
        set_geometry(4'd15, 4'd15, 4'd15, POLICY_FIFO);
        send_access(48'hAAAA_AAAA_AAAA, 1);
        send_access(48'h5555_5555_5555, 0);
        send_access(48'hAAAA_AAAA_AAAA, 0);
        // Fully associative, byte blocks, four ways under LRU: fill, reuse, evict.
        set_geometry(4'd0, 4'd0, 4'd4, POLICY_LRU);
        for (int i = 0; i < 5; i++) send_access(48'(i), i[0]);
        send_access(48'd1, 0);
        send_access(48'd5, 0);
        send_access(48'd0, 0);
        // Shrinking the ways leaves stale lines; widening brings them back.
        write_reg(REG_WAYS_IN_USE, 4'd0);
        send_access(48'd3, 0);
        send_access(48'd9, 1);
        write_reg(REG_WAYS_IN_USE, 4'd8);
        send_access(48'd3, 0);
        send_access(48'd1, 0);

        // Random phases over several geometries and idling patterns.
        for (int ph = 0; ph < 12; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
                default: begin send_idle_pct = 6; recv_stall_pct = 6; end
            endcase
            pol = policy_t'(ph[0]);
            case (ph % 3)
                0: set_geometry(4'($urandom_range(8)), 4'($urandom_range(12)),
                                4'($urandom_range(1, 8)), pol);
                1: set_geometry(4'd2, 4'd0, 4'd8, pol);
                default: set_geometry(4'd8, 4'd12, 4'd1, pol);
            endcase
            random_phase(120);
            // Hold off until every expected result has come in, then carry on.
            while (pending_count != 0) @(negedge aclk);
        end

        while (pending_count != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        $display("Covered %0d accesses with %0d results (%0d hits) over twelve geometries,",
                 access_count, result_seen, hit_seen);
        $display("both replacement policies and four sender/receiver idling patterns.");
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("FAIL");
        $finish;
    end
endmodule
